// ===== rtl/fss_pkg.sv =====
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types, constants and helpers of the field splitter with strip.
// ----------------------------------------------------------------------------
`default_nettype none

package fss_pkg;

	localparam int unsigned MAX_TEXT_LEN_DEF = 65535;
	localparam int unsigned QUEUE_DEPTH      = 4;
	localparam int          CFG_IDX_W        = 3;
	localparam int          CFG_DATA_W       = 64;
	localparam int          POS_W            = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SPLIT_SET_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPLIT_SET_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STRIP_SET_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STRIP_SET_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_EMPTY     = 3'd4;

	typedef struct packed {
		logic             has_field;
		logic [POS_W-1:0] offset;
		logic [POS_W-1:0] length;
		logic             final_item;
	} fss_res_t;

	typedef struct packed {
		fss_res_t r0;
		fss_res_t r1;
		logic     two;
	} fss_entry_t;

	// length of a kept span, saturating at the field width
	function automatic logic [POS_W-1:0] span_len(input logic [POS_W-1:0] first,
		input logic [POS_W-1:0] last);
		logic [POS_W:0] d;
		d = {1'b0, last} - {1'b0, first} + {{POS_W{1'b0}}, 1'b1};
		return d[POS_W] ? {POS_W{1'b1}} : d[POS_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/fss_front.sv =====
// ----------------------------------------------------------------------------
// fss_front
// Holds configuration and field tracking state, classifies each byte and
// builds the result entry that the byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_front #(
	parameter int unsigned MAX_TEXT_LEN = fss_pkg::MAX_TEXT_LEN_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [fss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fss_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [7:0]                     text_byte,
	input  wire logic                           end_of_text,
	input  wire logic                           q_full,
	output logic                                push,
	output fss_pkg::fss_entry_t                 push_entry
);
	import fss_pkg::*;

	localparam logic [POS_W-1:0] POS_CAP =
		(MAX_TEXT_LEN < 65535) ? POS_W'(MAX_TEXT_LEN) : {POS_W{1'b1}};

	logic [63:0]      split_lo_q, split_hi_q, strip_lo_q, strip_hi_q;
	logic             keep_q;
	logic [POS_W-1:0] pos_q, begin_q, first_q, last_q;
	logic             seen_q;

	logic             accept, is_sep, is_strip, a_emit, b_emit;
	logic [POS_W-1:0] pos_inc, nbegin, nfirst, nlast;
	logic             nseen;
	fss_res_t         res_a, res_b, res_end, res_0;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_lo_q <= '0;
			split_hi_q <= '0;
			strip_lo_q <= '0;
			strip_hi_q <= '0;
			keep_q     <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SPLIT_SET_LOW:  split_lo_q <= cfg_data;
				REG_SPLIT_SET_HIGH: split_hi_q <= cfg_data;
				REG_STRIP_SET_LOW:  strip_lo_q <= cfg_data;
				REG_STRIP_SET_HIGH: strip_hi_q <= cfg_data;
				REG_KEEP_EMPTY:     keep_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		is_sep   = !text_byte[7] && (text_byte[6] ? split_hi_q[text_byte[5:0]]
			: split_lo_q[text_byte[5:0]]);
		is_strip = !text_byte[7] && (text_byte[6] ? strip_hi_q[text_byte[5:0]]
			: strip_lo_q[text_byte[5:0]]);
		pos_inc  = (pos_q < POS_CAP) ? pos_q + 1'b1 : POS_CAP;

		nbegin = begin_q;
		nfirst = first_q;
		nlast  = last_q;
		nseen  = seen_q;
		if (is_sep) begin
			nbegin = pos_inc;
			nseen  = 1'b0;
		end else if (!is_strip) begin
			if (!seen_q) begin
				nfirst = pos_q;
			end
			nlast = pos_q;
			nseen = 1'b1;
		end

		// field closed by a separator, from the state before this byte
		a_emit           = is_sep && (seen_q || keep_q);
		res_a.has_field  = 1'b1;
		res_a.offset     = seen_q ? first_q : begin_q;
		res_a.length     = seen_q ? span_len(first_q, last_q) : '0;
		res_a.final_item = 1'b0;

		// field closed by the end of the string
		b_emit           = end_of_text && (nseen || keep_q);
		res_b.has_field  = 1'b1;
		res_b.offset     = nseen ? nfirst : nbegin;
		res_b.length     = nseen ? span_len(nfirst, nlast) : '0;
		res_b.final_item = 1'b1;

		res_end            = '0;
		res_end.final_item = 1'b1;

		res_0            = a_emit ? res_a : (b_emit ? res_b : res_end);
		res_0.final_item = end_of_text && !(a_emit && b_emit);

		push_entry.r0  = res_0;
		push_entry.r1  = res_b;
		push_entry.two = a_emit && b_emit;
		push           = accept && (a_emit || end_of_text);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			begin_q <= '0;
			first_q <= '0;
			last_q  <= '0;
			seen_q  <= 1'b0;
		end else if (accept) begin
			if (end_of_text) begin
				pos_q   <= '0;
				begin_q <= '0;
				first_q <= '0;
				last_q  <= '0;
				seen_q  <= 1'b0;
			end else begin
				pos_q   <= pos_inc;
				begin_q <= nbegin;
				first_q <= nfirst;
				last_q  <= nlast;
				seen_q  <= nseen;
			end
		end
	end

	a_last_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_text) |-> push)
		else $error("end of string accepted without a result entry");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_text) |=> (pos_q == '0 && !seen_q))
		else $error("tracking state not cleared after end of string");

endmodule

`default_nettype wire

// ===== rtl/fss_queue.sv =====
// ----------------------------------------------------------------------------
// fss_queue
// Short queue of result entries between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire fss_pkg::fss_entry_t push_entry,
	input  wire logic                pop,
	output fss_pkg::fss_entry_t      head,
	output logic                     full,
	output logic                     empty
);
	import fss_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	fss_entry_t      mem_q [QUEUE_DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;

	assign full  = (cnt_q == CW'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/fss_back.sv =====
// ----------------------------------------------------------------------------
// fss_back
// Drains queue entries one result at a time into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire fss_pkg::fss_entry_t head,
	input  wire logic                empty,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     has_field,
	output logic [15:0]              field_offset,
	output logic [15:0]              field_length,
	output logic                     final_item
);
	import fss_pkg::*;

	logic     valid_q, idx_q, load;
	fss_res_t res_q;

	assign load = !empty && (!valid_q || !out_stall);
	assign pop  = load && (!head.two || idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= head.two && !idx_q;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= idx_q ? head.r1 : head.r0;
		end
	end

	assign out_valid    = valid_q;
	assign has_field    = res_q.has_field;
	assign field_offset = res_q.offset;
	assign field_length = res_q.length;
	assign final_item   = res_q.final_item;

	a_second_half: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q |-> (!empty && head.two))
		else $error("second result pending without a two-result entry");

endmodule

`default_nettype wire

// ===== rtl/field_splitter_with_strip_core.sv =====
// ----------------------------------------------------------------------------
// field_splitter_with_strip_core
// Streaming field tokenizer: splits a byte string at separator characters
// and reports each field trimmed of strip characters as offset and length.
// ----------------------------------------------------------------------------
// path: a byte's entry goes into the queue, then into the output register
// throughput: one byte per cycle unless the queue is full; the output moves
//   one result per cycle unless stalled; two-field bytes give results in turn
// a four-entry queue between classifier and output lets both sides stall apart
// reset clears tracking state, queue and output valid; keep_empty resets to 1
`default_nettype none

module field_splitter_with_strip_core #(
	parameter int unsigned MAX_TEXT_LEN = fss_pkg::MAX_TEXT_LEN_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [fss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fss_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [7:0]                     text_byte,
	input  wire logic                           end_of_text,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                has_field,
	output logic [15:0]                         field_offset,
	output logic [15:0]                         field_length,
	output logic                                final_item
);
	import fss_pkg::*;

	logic       push, pop, q_full, q_empty;
	fss_entry_t push_entry, head;

	fss_front #(
		.MAX_TEXT_LEN(MAX_TEXT_LEN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	fss_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	fss_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (q_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.has_field   (has_field),
		.field_offset(field_offset),
		.field_length(field_length),
		.final_item  (final_item)
	);

endmodule

`default_nettype wire
